[sv/ism_pkg.sv]
// Shared opcodes and constants for the integer stack machine.
`default_nettype none
package ism_pkg;

  localparam int VAL_W       = 31;
  localparam int VALUE_LIMIT = 1000000000;

  typedef enum logic [3:0] {
    OP_START = 4'd0,
    OP_NUM   = 4'd1,
    OP_POP   = 4'd2,
    OP_INV   = 4'd3,
    OP_DUP   = 4'd4,
    OP_SWP   = 4'd5,
    OP_ADD   = 4'd6,
    OP_SUB   = 4'd7,
    OP_MUL   = 4'd8,
    OP_DIV   = 4'd9,
    OP_MOD   = 4'd10,
    OP_END   = 4'd11
  } op_t;

endpackage
`default_nettype wire

[sv/ism_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ism_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[sv/integer_stack_machine.sv]
// Integer stack machine: top level with stack RAM, sequencer and serial divider.
// Path: START, NUM, POP retire in S_IDLE; INV, DUP go S_RDA, S_EXEC, S_WB;
//   ADD, SUB add S_RDB; SWP goes S_RDA, S_RDB, S_EXEC, S_SWP2; MUL adds S_MUL
//   and DIV, MOD S_DIV (31-step restoring divider); END passes S_END.
// Throughput: one word at a time; the next word is taken when the previous one
//   retires, no result stalled; rate set by the single RAM read port and divider.
// Reset: rst (sync, active high) empties the stack and clears the error flag;
//   the stack RAM is not cleared, entries above the count are never read.
`default_nettype none
module integer_stack_machine
  import ism_pkg::*;
#(
  parameter int STACK_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [30:0] operand, [31] zero pad
  input  wire logic [3:0]  s_tuser,   // [3:0] operation
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [30:0] value, [31] zero pad
  output logic [0:0]       m_tuser    // [0] error
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
  localparam logic signed [32:0] LIM33 = 33'(VALUE_LIMIT);
  localparam logic signed [61:0] LIM62 = 62'(VALUE_LIMIT);
  localparam logic signed [30:0] LIM31 = 31'(VALUE_LIMIT);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDA  = 9'b000000010,
    S_RDB  = 9'b000000100,
    S_EXEC = 9'b000001000,
    S_MUL  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_WB   = 9'b001000000,
    S_SWP2 = 9'b010000000,
    S_END  = 9'b100000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0]         cnt, cnt_next;
  logic                  err, err_next;
  op_t                   op_q;
  logic signed [30:0]    a_q, b_q;
  logic signed [32:0]    res_q;
  logic signed [61:0]    prod_q;
  logic                  big_q;
  logic [AW-1:0]         waddr_q;
  logic [CW-1:0]         cnt_wb_q;
  logic                  bad_q;

  // divider
  logic [30:0]           dq, rem, dvs;
  logic [4:0]            dcnt;
  logic                  neg_q, neg_r;
  logic [31:0]           rem_sh;
  logic                  ge;

  // RAM port
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [30:0]           wdata, rdata;

  logic                  acc;
  op_t                   in_op;
  logic signed [30:0]    in_val;
  logic                  in_oor;
  logic [CW-1:0]         cnt_m1, cnt_m2;

  assign in_op    = op_t'(s_tuser);
  assign in_val   = $signed(s_tdata[30:0]);
  assign in_oor   = (in_val > LIM31) || (in_val < -LIM31);
  assign s_tready = (state == S_IDLE) && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;
  assign cnt_m1   = cnt - CW'(1);
  assign cnt_m2   = cnt - CW'(2);
  assign rem_sh   = {rem, dq[30]};
  assign ge       = rem_sh >= {1'b0, dvs};

  function automatic logic [30:0] mag(input logic signed [30:0] x);
    mag = x[30] ? 31'(-x) : 31'(x);
  endfunction

  ism_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // sequencer, RAM port and counters
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    err_next   = err;
    we         = 1'b0;
    waddr      = waddr_q;
    wdata      = res_q[30:0];
    raddr      = cnt_m1[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (in_op == OP_START) begin
            if (in_oor) begin
              err_next = 1'b1;
              cnt_next = '0;
            end else begin
              err_next = 1'b0;
              we       = 1'b1;
              waddr    = '0;
              wdata    = in_val;
              cnt_next = CW'(1);
            end
          end else if (in_op == OP_END) begin
            raddr      = '0;
            cnt_next   = '0;
            err_next   = 1'b0;
            state_next = S_END;
          end else if (!err) begin
            unique case (in_op)
              OP_NUM: begin
                if (cnt == CNT_FULL || in_oor) begin
                  err_next = 1'b1;
                end else begin
                  we       = 1'b1;
                  waddr    = cnt[AW-1:0];
                  wdata    = in_val;
                  cnt_next = cnt + CW'(1);
                end
              end
              OP_POP: begin
                if (cnt == '0) err_next = 1'b1;
                else           cnt_next = cnt_m1;
              end
              OP_INV: begin
                if (cnt == '0) err_next = 1'b1;
                else           state_next = S_RDA;
              end
              OP_DUP: begin
                if (cnt == '0 || cnt == CNT_FULL) err_next = 1'b1;
                else                              state_next = S_RDA;
              end
              OP_SWP, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
                if (cnt < CW'(2)) err_next = 1'b1;
                else              state_next = S_RDA;
              end
              default: ;
            endcase
          end
        end
      end
      S_RDA: begin
        raddr = cnt_m2[AW-1:0];
        state_next = (op_q == OP_INV || op_q == OP_DUP) ? S_EXEC : S_RDB;
      end
      S_RDB: state_next = S_EXEC;
      S_EXEC: begin
        unique case (op_q)
          OP_SWP: begin
            we         = 1'b1;
            waddr      = cnt_m1[AW-1:0];
            wdata      = b_q;
            state_next = S_SWP2;
          end
          OP_MUL: state_next = S_MUL;
          OP_DIV, OP_MOD: begin
            if (a_q == '0) begin
              err_next   = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_DIV;
            end
          end
          default: state_next = S_WB;
        endcase
      end
      S_MUL: state_next = S_WB;
      S_DIV: if (dcnt == '0) state_next = S_WB;
      S_SWP2: begin
        we         = 1'b1;
        waddr      = cnt_m2[AW-1:0];
        wdata      = a_q;
        state_next = S_IDLE;
      end
      S_WB: begin
        if (big_q || res_q > LIM33 || res_q < -LIM33) begin
          err_next = 1'b1;
        end else begin
          we       = 1'b1;
          cnt_next = cnt_wb_q;
        end
        state_next = S_IDLE;
      end
      S_END: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      err   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      err   <= err_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q  <= in_op;
      bad_q <= err || (cnt != CW'(1));
    end
    if (state == S_RDA) a_q <= $signed(rdata);
    if (state == S_RDB) b_q <= $signed(rdata);
    if (state == S_EXEC) begin
      big_q  <= 1'b0;
      prod_q <= b_q * a_q;
      dq     <= mag(b_q);
      dvs    <= mag(a_q);
      rem    <= '0;
      dcnt   <= 5'd31;
      neg_q  <= b_q[30] ^ a_q[30];
      neg_r  <= b_q[30];
      unique case (op_q)
        OP_INV: begin
          res_q    <= -33'(a_q);
          waddr_q  <= cnt_m1[AW-1:0];
          cnt_wb_q <= cnt;
        end
        OP_DUP: begin
          res_q    <= 33'(a_q);
          waddr_q  <= cnt[AW-1:0];
          cnt_wb_q <= cnt + CW'(1);
        end
        OP_SUB: begin
          res_q    <= 33'(b_q) - 33'(a_q);
          waddr_q  <= cnt_m2[AW-1:0];
          cnt_wb_q <= cnt_m1;
        end
        default: begin
          res_q    <= 33'(b_q) + 33'(a_q);
          waddr_q  <= cnt_m2[AW-1:0];
          cnt_wb_q <= cnt_m1;
        end
      endcase
    end
    if (state == S_MUL) begin
      big_q <= (prod_q > LIM62) || (prod_q < -LIM62);
      res_q <= $signed(prod_q[32:0]);
    end
    if (state == S_DIV) begin
      if (dcnt != '0) begin
        rem  <= ge ? 31'(rem_sh - {1'b0, dvs}) : rem_sh[30:0];
        dq   <= {dq[29:0], ge};
        dcnt <= dcnt - 5'd1;
      end else if (op_q == OP_DIV) begin
        res_q <= neg_q ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
      end else begin
        res_q <= neg_r ? -$signed({2'b00, rem}) : $signed({2'b00, rem});
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_END) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_END) begin
      m_tdata <= {1'b0, (bad_q ? 31'd0 : rdata)};
      m_tuser <= bad_q;
    end
  end

endmodule
`default_nettype wire

[sv/ism_checker.sv]
// Port-level checker for the integer stack machine, bound to the top level.
`default_nettype none
module ism_checker
  import ism_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [3:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
    else $error("error result carries nonzero value");

  a_no_take: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == OP_END, 2))
    else $error("result without END");

endmodule

bind integer_stack_machine ism_checker u_ism_checker (.*);
`default_nettype wire
